FILE: hw/rtl/sib_pkg.sv
// Shared types and constants for the sorted interval binning core.
// Holds the command codes and the fixed layout of the stream beats.
// No dependencies.
`timescale 1ns / 1ps

package sib_pkg;

	// Command carried in the slave-side tuser of each beat
	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_LOAD   = 2'd1,
		CMD_RECORD = 2'd2,
		CMD_REWIND = 2'd3
	} cmd_t;

	// Field widths fixed by the stream layout
	localparam int unsigned ID_W    = 8;
	localparam int unsigned COORD_W = 32;
	localparam int unsigned CSLOT_W = 6;
	localparam int unsigned ISLOT_W = 12;
	localparam int unsigned CMD_W   = 2;

	// Slave-side tdata: chrom_id, interval_begin, interval_finish, position
	localparam int unsigned ID_LO     = 0;
	localparam int unsigned BEGIN_LO  = ID_LO + ID_W;
	localparam int unsigned FINISH_LO = BEGIN_LO + COORD_W;
	localparam int unsigned POS_LO    = FINISH_LO + COORD_W;
	localparam int unsigned S_DATA_W  = POS_LO + COORD_W;

	// Master-side tdata: chrom_slot, interval_slot, hit_position, zero fill
	localparam int unsigned M_USED_W = CSLOT_W + ISLOT_W + COORD_W;
	localparam int unsigned M_DATA_W = ((M_USED_W + 7) / 8) * 8;
	localparam int unsigned M_PAD_W  = M_DATA_W - M_USED_W;

endpackage

FILE: hw/rtl/sorted_interval_binning_core.sv
// Sorted interval binning core: merges a sorted position stream against a
// loaded table of half-open intervals grouped by chromosome.
// Depends on sib_pkg and sib_interval_ram.
//
// Usage: every slave-side beat carries a command in tuser (clear, load
// interval, position record, rewind) and the chromosome id and coordinates in
// tdata. Loads with the same id as the previous load extend that chromosome;
// a new id opens the next one. Position records, sorted within chromosome,
// are matched against the table; a record inside the current interval gives
// one master-side beat with its chromosome slot, interval slot and position.
// Records on unlisted chromosomes give nothing, and once the stream has left
// the last listed chromosome nothing is given until a rewind or a clear.
// Flow: clear and rewind finish in the idle state, a load in a load state.
// A record passes a decide state and, when it reaches the interval compare,
// a scan state that moves the cursor past one interval per memory read; a
// skipped record returns to idle from the decide state. The memory read and
// its compare form the scan loop; the result then goes to an output register.
// Reset empties the table and rewinds the cursors at once, with no sweep.
// When the receiver stalls, the next beat is still taken; only a second
// result waits, in a hold state, until the output register drains.
`timescale 1ns / 1ps

module sorted_interval_binning_core #(
	parameter int unsigned MAX_INTERVALS = 4096,
	parameter int unsigned MAX_CHROMS    = 64,
	parameter int unsigned POS_WIDTH     = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// chrom_id, interval_begin, interval_finish, position
	input  logic [sib_pkg::S_DATA_W-1:0] s_axis_tdata,
	// cmd
	input  logic [sib_pkg::CMD_W-1:0]    s_axis_tuser,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// chrom_slot, interval_slot, hit_position, zero fill
	output logic [sib_pkg::M_DATA_W-1:0] m_axis_tdata
);

	// Coordinates are kept at the masked width
	localparam int unsigned SW  = (POS_WIDTH < sib_pkg::COORD_W) ? POS_WIDTH : sib_pkg::COORD_W;
	localparam int unsigned IIW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
	localparam int unsigned ICW = $clog2(MAX_INTERVALS + 1);
	localparam int unsigned CIW = (MAX_CHROMS > 1) ? $clog2(MAX_CHROMS) : 1;
	localparam int unsigned CCW = $clog2(MAX_CHROMS + 1);
	localparam int unsigned IDW = sib_pkg::ID_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DECIDE,
		ST_SCAN,
		ST_HOLD
	} state_t;

	// Control state
	state_t         state_q, state_d;
	logic [ICW-1:0] ic_q, ic_d;
	logic [CCW-1:0] cc_q, cc_d;
	logic [CIW-1:0] last_idx_q, last_idx_d;
	logic [ICW-1:0] last_size_q, last_size_d;
	logic [IDW-1:0] seen_chrom_q, seen_chrom_d;
	logic           seen_valid_q, seen_valid_d;
	logic           fm_q, fm_d;
	logic [CIW-1:0] cursor_q, cursor_d;
	logic           cvalid_q, cvalid_d;
	logic [IIW-1:0] icur_q, icur_d;
	logic           stopped_q, stopped_d;
	logic           first_q, first_d;
	logic           out_valid_q, out_valid_d;

	// Payload registers
	sib_pkg::cmd_t  cmd_s1;
	logic [IDW-1:0] id_s1;
	logic [SW-1:0]  begin_s1, finish_s1, pos_s1;
	logic [IDW-1:0] last_name_q, last_name_d;
	logic [IDW-1:0] cur_name_q, cur_name_d;
	logic [ICW-1:0] cur_size_q, cur_size_d;
	logic [IIW-1:0] idx_q, idx_d;
	logic [sib_pkg::CSLOT_W-1:0] out_cslot_q;
	logic [sib_pkg::ISLOT_W-1:0] out_islot_q;
	logic [sib_pkg::COORD_W-1:0] out_hit_q;

	// Chromosome table memories and their registered read of the next slot
	logic [IDW-1:0] name_mem [MAX_CHROMS];
	logic [IIW-1:0] base_mem [MAX_CHROMS];
	logic [ICW-1:0] size_mem [MAX_CHROMS];
	logic [IDW-1:0] name_rd_q;
	logic [IIW-1:0] base_rd_q;
	logic [ICW-1:0] size_rd_q;
	logic [CIW-1:0] next_addr;
	logic           cnew_we, csize_we;
	logic [CIW-1:0] cw_addr;
	logic [ICW-1:0] size_wdata;

	// Interval memory port
	logic            ram_we;
	logic [IIW-1:0]  ram_raddr;
	logic [2*SW-1:0] ram_rdata;
	logic [SW-1:0]   rd_start, rd_end;

	// Combinational helpers
	logic accept_in, out_free, load_out;
	logic new_chrom, seen_new, fm_v, can_step, move;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept_in     = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign rd_start      = ram_rdata[SW-1:0];
	assign rd_end        = ram_rdata[2*SW-1:SW];

	// Slot after the cursor; the first slot when the cursor is not yet valid or sits on the last slot
	always_comb begin
		if (cvalid_q && (cursor_q != CIW'(MAX_CHROMS - 1))) begin
			next_addr = cursor_q + 1'b1;
		end else begin
			next_addr = '0;
		end
	end

	// Next-state and datapath decisions
	always_comb begin
		state_d     = state_q;
		ic_d        = ic_q;
		cc_d        = cc_q;
		last_idx_d  = last_idx_q;
		last_size_d = last_size_q;
		last_name_d = last_name_q;
		seen_chrom_d = seen_chrom_q;
		seen_valid_d = seen_valid_q;
		fm_d        = fm_q;
		cursor_d    = cursor_q;
		cvalid_d    = cvalid_q;
		icur_d      = icur_q;
		stopped_d   = stopped_q;
		first_d     = first_q;
		cur_name_d  = cur_name_q;
		cur_size_d  = cur_size_q;
		idx_d       = idx_q;
		ram_we      = 1'b0;
		ram_raddr   = idx_q + 1'b1;
		cnew_we     = 1'b0;
		csize_we    = 1'b0;
		cw_addr     = last_idx_q;
		size_wdata  = last_size_q + 1'b1;
		load_out    = 1'b0;
		new_chrom   = (cc_q == '0) || (last_name_q != id_s1);
		seen_new    = !seen_valid_q || (seen_chrom_q != id_s1);
		fm_v        = seen_new ? 1'b0 : fm_q;
		can_step    = !cvalid_q || ((CCW'(cursor_q) + 1'b1) < cc_q);
		move        = can_step && (name_rd_q == id_s1);

		case (state_q)
			ST_IDLE: begin
				if (accept_in) begin
					case (sib_pkg::cmd_t'(s_axis_tuser))
						sib_pkg::CMD_CLEAR, sib_pkg::CMD_REWIND: begin
							if (sib_pkg::cmd_t'(s_axis_tuser) == sib_pkg::CMD_CLEAR) begin
								ic_d = '0;
								cc_d = '0;
							end
							seen_chrom_d = '0;
							seen_valid_d = 1'b0;
							fm_d         = 1'b0;
							cursor_d     = '0;
							cvalid_d     = 1'b0;
							icur_d       = '0;
							stopped_d    = 1'b0;
						end
						sib_pkg::CMD_LOAD: begin
							state_d = ST_LOAD;
						end
						sib_pkg::CMD_RECORD: begin
							state_d = ST_DECIDE;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end

			// Append one interval, opening a chromosome when the id changes
			ST_LOAD: begin
				state_d = ST_IDLE;
				if (ic_q != ICW'(MAX_INTERVALS)) begin
					if (new_chrom) begin
						if (cc_q != CCW'(MAX_CHROMS)) begin
							ram_we      = 1'b1;
							cnew_we     = 1'b1;
							csize_we    = 1'b1;
							cw_addr     = CIW'(cc_q);
							size_wdata  = ICW'(1);
							last_idx_d  = CIW'(cc_q);
							last_size_d = ICW'(1);
							last_name_d = id_s1;
							cc_d        = cc_q + 1'b1;
							ic_d        = ic_q + 1'b1;
						end
					end else begin
						ram_we      = 1'b1;
						csize_we    = 1'b1;
						last_size_d = last_size_q + 1'b1;
						ic_d        = ic_q + 1'b1;
						if (cvalid_q && (cursor_q == last_idx_q)) begin
							cur_size_d = cur_size_q + 1'b1;
						end
					end
				end
			end

			// Chromosome cursor decision and the first interval read
			ST_DECIDE: begin
				state_d   = ST_IDLE;
				ram_raddr = move ? base_rd_q : idx_q;
				if (!stopped_q && (cc_q != '0)) begin
					seen_chrom_d = id_s1;
					seen_valid_d = 1'b1;
					fm_d         = fm_v;
					if (can_step) begin
						if (move) begin
							cursor_d   = next_addr;
							cvalid_d   = 1'b1;
							icur_d     = '0;
							fm_d       = 1'b1;
							cur_name_d = name_rd_q;
							cur_size_d = size_rd_q;
							idx_d      = base_rd_q;
							first_d    = 1'b1;
							state_d    = ST_SCAN;
						end else if (fm_v && cvalid_q) begin
							first_d = 1'b1;
							state_d = ST_SCAN;
						end
					end else if (cur_name_q != id_s1) begin
						stopped_d = 1'b1;
					end else begin
						first_d = 1'b1;
						state_d = ST_SCAN;
					end
				end
			end

			// Walk the interval cursor forward, one memory read a cycle
			ST_SCAN: begin
				first_d = 1'b0;
				if (first_q && (pos_s1 < rd_start)) begin
					state_d = ST_IDLE;
				end else if ((rd_end <= pos_s1) &&
					((ICW'(icur_q) + 1'b1) < cur_size_q)) begin
					icur_d = icur_q + 1'b1;
					idx_d  = idx_q + 1'b1;
				end else if ((cur_name_q == id_s1) && (rd_start <= pos_s1) &&
					(pos_s1 < rd_end)) begin
					if (out_free) begin
						load_out = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						state_d = ST_HOLD;
					end
				end else begin
					state_d = ST_IDLE;
				end
			end

			// Result waits for the output register to drain
			ST_HOLD: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// Output register handshake
		if (load_out) begin
			out_valid_d = 1'b1;
		end else if (m_axis_tready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	// State machine and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ic_q         <= '0;
			cc_q         <= '0;
			last_idx_q   <= '0;
			last_size_q  <= '0;
			seen_chrom_q <= '0;
			seen_valid_q <= 1'b0;
			fm_q         <= 1'b0;
			cursor_q     <= '0;
			cvalid_q     <= 1'b0;
			icur_q       <= '0;
			stopped_q    <= 1'b0;
			first_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			ic_q         <= ic_d;
			cc_q         <= cc_d;
			last_idx_q   <= last_idx_d;
			last_size_q  <= last_size_d;
			seen_chrom_q <= seen_chrom_d;
			seen_valid_q <= seen_valid_d;
			fm_q         <= fm_d;
			cursor_q     <= cursor_d;
			cvalid_q     <= cvalid_d;
			icur_q       <= icur_d;
			stopped_q    <= stopped_d;
			first_q      <= first_d;
			out_valid_q  <= out_valid_d;
		end
	end

	// Beat capture, cursor cache and result payload
	always_ff @(posedge clk) begin
		if (accept_in) begin
			cmd_s1    <= sib_pkg::cmd_t'(s_axis_tuser);
			id_s1     <= s_axis_tdata[sib_pkg::ID_LO +: IDW];
			begin_s1  <= s_axis_tdata[sib_pkg::BEGIN_LO +: SW];
			finish_s1 <= s_axis_tdata[sib_pkg::FINISH_LO +: SW];
			pos_s1    <= s_axis_tdata[sib_pkg::POS_LO +: SW];
		end
		last_name_q <= last_name_d;
		cur_name_q  <= cur_name_d;
		cur_size_q  <= cur_size_d;
		idx_q       <= idx_d;
		if (load_out) begin
			out_cslot_q <= sib_pkg::CSLOT_W'(cursor_q);
			out_islot_q <= sib_pkg::ISLOT_W'(icur_q);
			out_hit_q   <= sib_pkg::COORD_W'(pos_s1);
		end
	end

	// Chromosome table: writes from loads, read of the slot after the cursor
	always_ff @(posedge clk) begin
		if (cnew_we) begin
			name_mem[cw_addr] <= id_s1;
			base_mem[cw_addr] <= IIW'(ic_q);
		end
		if (csize_we) begin
			size_mem[cw_addr] <= size_wdata;
		end
		name_rd_q <= name_mem[next_addr];
		base_rd_q <= base_mem[next_addr];
		size_rd_q <= size_mem[next_addr];
	end

	// Interval start and end store
	sib_interval_ram #(
		.DEPTH (MAX_INTERVALS),
		.AW    (IIW),
		.DW    (2 * SW)
	) u_interval_ram (
		.clk     (clk),
		.wr_en   (ram_we && (cmd_s1 == sib_pkg::CMD_LOAD)),
		.wr_addr (IIW'(ic_q)),
		.wr_data ({finish_s1, begin_s1}),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{sib_pkg::M_PAD_W{1'b0}}, out_hit_q, out_islot_q, out_cslot_q};

endmodule

FILE: hw/rtl/sib_interval_ram.sv
// Single-port-write, single-port-read interval store of the binning core.
// Each word holds the exclusive end above the inclusive start of one interval.
// No dependencies.
`timescale 1ns / 1ps

module sib_interval_ram #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = 12,
	parameter int unsigned DW    = 64
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: bench/tb.sv
// Self-checking bench for sorted_interval_binning_core: drives load, record, clear
// and rewind beats and predicts every hit beat the core should give.
// Depends on sib_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;

	localparam int unsigned MAX_IV      = 4096;
	localparam int unsigned MAX_CHR     = 64;
	localparam int unsigned STALL_LIMIT = 20000;
	localparam int unsigned TAIL_CYCLES = 4200;
	localparam int unsigned LONG_IV     = 600;
	localparam int unsigned ITEMS       = 1900;

	typedef struct {
		logic [sib_pkg::CSLOT_W-1:0] cslot;
		logic [sib_pkg::ISLOT_W-1:0] islot;
		logic [sib_pkg::COORD_W-1:0] pos;
	} hit_t;

	logic                         clk;
	logic                         arst_n        = 1'b0;
	logic                         s_axis_tvalid = 1'b0;
	logic                         s_axis_tready;
	logic [sib_pkg::S_DATA_W-1:0] s_axis_tdata  = '0;
	logic [sib_pkg::CMD_W-1:0]    s_axis_tuser  = sib_pkg::CMD_REWIND;
	logic                         m_axis_tvalid;
	logic                         m_axis_tready = 1'b0;
	logic [sib_pkg::M_DATA_W-1:0] m_axis_tdata;

	// Shared bench state.
	bit          gapless;
	int unsigned errors;
	int unsigned beats_in;
	hit_t        pending_hits[$];

	// Predicted copy of the interval table and the merge cursors.
	logic [sib_pkg::COORD_W-1:0] iv_lo [MAX_IV];
	logic [sib_pkg::COORD_W-1:0] iv_hi [MAX_IV];
	logic [sib_pkg::ID_W-1:0]    chr_name [MAX_CHR];
	int unsigned                 chr_first [MAX_CHR];
	int unsigned                 chr_count [MAX_CHR];
	int unsigned                 n_chr, n_iv;
	logic [sib_pkg::ID_W-1:0]    last_id;
	bit                          last_id_ok, id_hit, cur_chr_ok, halted;
	int unsigned                 cur_chr, cur_iv;

	sorted_interval_binning_core #(
		.MAX_INTERVALS(MAX_IV),
		.MAX_CHROMS   (MAX_CHR),
		.POS_WIDTH    (sib_pkg::COORD_W)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Cursor rewind: the table is kept, the merge starts again from the top.
	function automatic void rewind_merge();
		last_id    = '0;
		last_id_ok = 1'b0;
		id_hit     = 1'b0;
		cur_chr    = 0;
		cur_chr_ok = 1'b0;
		cur_iv     = 0;
		halted     = 1'b0;
	endfunction

	// A load extends the last chromosome when the id repeats, else opens a new one.
	function automatic void table_load(logic [sib_pkg::ID_W-1:0] id,
			logic [sib_pkg::COORD_W-1:0] lo, logic [sib_pkg::COORD_W-1:0] hi);
		if (n_iv >= MAX_IV)
			return;
		if (n_chr == 0 || chr_name[n_chr-1] != id) begin
			if (n_chr >= MAX_CHR)
				return;
			chr_name[n_chr]  = id;
			chr_first[n_chr] = n_iv;
			chr_count[n_chr] = 0;
			n_chr++;
		end
		iv_lo[n_iv] = lo;
		iv_hi[n_iv] = hi;
		chr_count[n_chr-1]++;
		n_iv++;
	endfunction

	// Merge one position against the table; returns 1 with the hit when it lands
	// inside the current interval.
	function automatic bit merge_position(logic [sib_pkg::ID_W-1:0] id,
			logic [sib_pkg::COORD_W-1:0] p, output hit_t h);
		int unsigned nxt, idx;
		h = '{default: '0};
		if (halted || n_chr == 0)
			return 1'b0;
		if (!last_id_ok || last_id != id) begin
			last_id    = id;
			last_id_ok = 1'b1;
			id_hit     = 1'b0;
		end
		// Chromosome cursor only ever steps to the next table entry.
		if (!cur_chr_ok || cur_chr + 1 < n_chr) begin
			nxt = cur_chr_ok ? cur_chr + 1 : 0;
			if (chr_name[nxt] == id) begin
				cur_chr    = nxt;
				cur_chr_ok = 1'b1;
				cur_iv     = 0;
				id_hit     = 1'b1;
			end else if (!id_hit) begin
				return 1'b0;
			end
		end else if (chr_name[cur_chr] != id) begin
			halted = 1'b1;
			return 1'b0;
		end
		if (!cur_chr_ok || cur_chr >= n_chr)
			return 1'b0;
		if (chr_count[cur_chr] == 0 || cur_iv >= chr_count[cur_chr])
			return 1'b0;
		idx = (chr_first[cur_chr] + cur_iv) % MAX_IV;
		if (p < iv_lo[idx])
			return 1'b0;
		// Interval cursor walks forward past every interval that ends at or below p.
		while (iv_hi[idx] <= p && cur_iv + 1 < chr_count[cur_chr]) begin
			cur_iv++;
			idx = (chr_first[cur_chr] + cur_iv) % MAX_IV;
		end
		if (chr_name[cur_chr] == id && iv_lo[idx] <= p && p < iv_hi[idx]) begin
			h.cslot = cur_chr[sib_pkg::CSLOT_W-1:0];
			h.islot = cur_iv[sib_pkg::ISLOT_W-1:0];
			h.pos   = p;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Sends one beat, with a random gap in front unless the bench runs gapless,
	// and updates the prediction once the core has taken it.
	task automatic send_beat(sib_pkg::cmd_t op, logic [sib_pkg::ID_W-1:0] id,
			logic [sib_pkg::COORD_W-1:0] lo, logic [sib_pkg::COORD_W-1:0] hi,
			logic [sib_pkg::COORD_W-1:0] pos);
		hit_t h;
		if (!gapless) begin
			while ($urandom_range(99) < 25) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {pos, hi, lo, id};
		do
			@(posedge clk);
		while (!s_axis_tready);
		beats_in++;
		case (op)
			sib_pkg::CMD_CLEAR: begin
				n_chr = 0;
				n_iv  = 0;
				rewind_merge();
			end
			sib_pkg::CMD_LOAD:   table_load(id, lo, hi);
			sib_pkg::CMD_RECORD: if (merge_position(id, pos, h)) pending_hits.push_back(h);
			default:             rewind_merge();
		endcase
	endtask

	task automatic send_load(logic [sib_pkg::ID_W-1:0] id, logic [sib_pkg::COORD_W-1:0] lo,
			logic [sib_pkg::COORD_W-1:0] hi);
		send_beat(sib_pkg::CMD_LOAD, id, lo, hi, $urandom);
	endtask

	task automatic send_record(logic [sib_pkg::ID_W-1:0] id,
			logic [sib_pkg::COORD_W-1:0] pos);
		send_beat(sib_pkg::CMD_RECORD, id, $urandom, $urandom, pos);
	endtask

	task automatic send_control(sib_pkg::cmd_t op);
		send_beat(op, 8'($urandom), $urandom, $urandom, $urandom);
	endtask

	// Holds the sender off until every predicted hit has come out.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_hits.size() != 0)
			@(posedge clk);
	endtask

	// Empty table, bounds of the coordinate range, unlisted ids, a position below
	// the interval, empty intervals, the stop, a load mid-stream, rewind and clear.
	task automatic test_directed_cases();
		send_control(sib_pkg::CMD_CLEAR);
		send_record(8'd3, 32'd5);
		send_load(8'd5, 32'd100, 32'd200);
		send_load(8'd5, 32'd300, 32'd400);
		send_load(8'd0, 32'd0, 32'd10);
		send_load(8'd0, 32'd10, 32'd10);
		send_load(8'hFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
		send_record(8'd9, 32'd150);
		send_record(8'd5, 32'd50);
		send_record(8'd5, 32'd100);
		send_record(8'd5, 32'd199);
		send_record(8'd5, 32'd250);
		send_record(8'd5, 32'd399);
		send_record(8'd5, 32'd500);
		send_record(8'd0, 32'd0);
		send_record(8'd0, 32'd9);
		send_record(8'd0, 32'd10);
		send_record(8'hFF, 32'hFFFF_FFFE);
		send_load(8'hFF, 32'd0, 32'hFFFF_FFFF);
		send_record(8'hFF, 32'hFFFF_FFFF);
		send_record(8'd7, 32'd1);
		send_record(8'hFF, 32'hFFFF_FFF1);
		send_control(sib_pkg::CMD_REWIND);
		send_record(8'd5, 32'd150);
		send_control(sib_pkg::CMD_CLEAR);
		send_record(8'd5, 32'd150);
	endtask

	// Fills the chromosome table, tries one chromosome too many and walks all slots.
	task automatic test_chrom_capacity();
		int unsigned k;
		send_control(sib_pkg::CMD_CLEAR);
		for (k = 0; k < MAX_CHR; k++)
			send_load(8'(k * 4 + 2), 32'(k * 100), 32'(k * 100 + 50));
		send_load(8'hFF, 32'd0, 32'd1000);
		for (k = 0; k < MAX_CHR; k++)
			send_record(8'(k * 4 + 2), 32'(k * 100 + k % 50));
		send_record(8'hFF, 32'd10);
		send_record(8'd2, 32'd10);
	endtask

	// Loads one long chromosome, then forces long cursor walks up to its last
	// interval and past its end.
	task automatic test_long_walks();
		int unsigned k;
		send_control(sib_pkg::CMD_CLEAR);
		for (k = 0; k < LONG_IV; k++)
			send_load(8'h80, 32'(k * 16), 32'(k * 16 + 8));
		send_load(8'h81, 32'd0, 32'd100);
		send_record(8'h80, 32'd0);
		send_record(8'h80, 32'((LONG_IV / 2) * 16 + 3));
		send_record(8'h80, 32'((LONG_IV - 1) * 16 + 7));
		send_record(8'h80, 32'((LONG_IV - 1) * 16 + 8));
		send_record(8'h80, 32'(LONG_IV * 16));
		drain_results();
	endtask

	// Random tables of a few chromosomes, each followed by a sorted stream with
	// some stray ids, unsorted records, noise beats, mid-stream loads and stops.
	task automatic test_random_streams();
		logic [sib_pkg::ID_W-1:0] ids[$];
		longint unsigned          span_lo[$], span_hi[$], ps[$];
		longint unsigned          cur, lo, hi, pmin;
		int unsigned              nchr, niv, npos, set_no, c, k;
		set_no = 0;
		while (beats_in < ITEMS) begin
			set_no++;
			gapless = (set_no >= 8 && set_no < 16);
			if (set_no == 3 || set_no % 16 == 0)
				drain_results();
			if ($urandom_range(4) != 0)
				send_control(sib_pkg::CMD_CLEAR);
			else
				send_control(sib_pkg::CMD_REWIND);

			// Build the table.
			ids.delete();
			span_lo.delete();
			span_hi.delete();
			nchr = $urandom_range(6, 1);
			for (c = 0; c < nchr; c++) begin
				ids.push_back(8'($urandom_range(255)));
				case ($urandom_range(9))
					0:       cur = 0;
					1:       cur = 32'hFFFF_FC00;
					default: cur = $urandom_range(32'hF000_0000);
				endcase
				niv = $urandom_range(8, 1);
				for (k = 0; k < niv; k++) begin
					lo = cur + $urandom_range(40);
					hi = lo + $urandom_range(30);
					send_load(ids[c], 32'(lo), 32'(hi));
					if (k == 0)
						span_lo.push_back(lo);
					cur = hi;
				end
				span_hi.push_back(cur);
			end

			// Stream the positions chromosome by chromosome.
			for (c = 0; c < nchr; c++) begin
				if ($urandom_range(7) == 0)
					continue;
				ps.delete();
				pmin = span_lo[c] >= 10 ? span_lo[c] - 10 : 0;
				npos = $urandom_range(10, 1);
				repeat (npos)
					ps.push_back($urandom_range(32'(span_hi[c] + 10), 32'(pmin)));
				ps.sort();
				for (k = 0; k < npos; k++) begin
					if ($urandom_range(9) == 0)
						send_record(8'($urandom_range(255)), $urandom);
					if ($urandom_range(39) == 0)
						send_beat(sib_pkg::cmd_t'($urandom_range(3)), 8'($urandom),
							$urandom, $urandom, $urandom);
					if ($urandom_range(29) == 0)
						ps[k] = $urandom;
					send_record(ids[c], 32'(ps[k]));
				end
				if ($urandom_range(9) == 0)
					send_load(ids[nchr-1], 32'(span_hi[nchr-1]), 32'(span_hi[nchr-1] + 20));
			end

			// Leave the last chromosome, then try records that must be ignored.
			if ($urandom_range(1) == 0) begin
				send_record(ids[nchr-1] + 8'd1, $urandom);
				send_record(ids[0], 32'(span_lo[0]));
			end
			if ($urandom_range(3) == 0) begin
				send_control(sib_pkg::CMD_REWIND);
				send_record(ids[0], 32'(span_lo[0]));
			end
		end
		gapless = 1'b0;
	endtask

	// Receiver stalls at random except while the bench runs gapless.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= gapless || ($urandom_range(99) >= 25);
		end
	end

	// Each hit beat is checked against the oldest predicted hit.
	always @(posedge clk) begin : check_hits
		hit_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_hits.size() == 0) begin
				$display("%0t: unexpected hit beat, expected none, got tdata %h", $time,
					m_axis_tdata);
				errors++;
			end else begin
				want = pending_hits.pop_front();
				if (m_axis_tdata[sib_pkg::CSLOT_W-1:0] !== want.cslot) begin
					$display("%0t: chrom_slot expected %0d, got %0d", $time, want.cslot,
						m_axis_tdata[sib_pkg::CSLOT_W-1:0]);
					errors++;
				end
				if (m_axis_tdata[sib_pkg::CSLOT_W +: sib_pkg::ISLOT_W] !== want.islot) begin
					$display("%0t: interval_slot expected %0d, got %0d", $time, want.islot,
						m_axis_tdata[sib_pkg::CSLOT_W +: sib_pkg::ISLOT_W]);
					errors++;
				end
				if (m_axis_tdata[sib_pkg::CSLOT_W + sib_pkg::ISLOT_W +: sib_pkg::COORD_W]
						!== want.pos) begin
					$display("%0t: hit_position expected %h, got %h", $time, want.pos,
						m_axis_tdata[sib_pkg::CSLOT_W + sib_pkg::ISLOT_W +: sib_pkg::COORD_W]);
					errors++;
				end
				if (m_axis_tdata[sib_pkg::M_DATA_W-1 -: sib_pkg::M_PAD_W] !== '0) begin
					$display("%0t: zero fill expected 0, got %h", $time,
						m_axis_tdata[sib_pkg::M_DATA_W-1 -: sib_pkg::M_PAD_W]);
					errors++;
				end
			end
		end
	end

	// Ends the run when no beat moves on either side for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_axis_tvalid && s_axis_tready) ||
					(m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: timeout, no beat accepted for %0d cycles", $time, STALL_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// Test sequence.
	initial begin
		gapless  = 1'b0;
		errors   = 0;
		beats_in = 0;
		n_chr    = 0;
		n_iv     = 0;
		rewind_merge();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_chrom_capacity();
		test_long_walks();
		test_random_streams();
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && pending_hits.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
